@@ hdl/smfk_pkg.sv @@
package smfk_pkg;

  localparam logic [7:0]  KISS_FEND  = 8'hC0;
  localparam logic [7:0]  KISS_FESC  = 8'hDB;
  localparam logic [7:0]  KISS_TFEND = 8'hDC;
  localparam logic [7:0]  KISS_TFESC = 8'hDD;

  localparam logic [31:0] SYNC_WORD_RESET    = 32'h1ACF_FC1D;
  localparam logic [15:0] FRAME_LENGTH_RESET = 16'd1024;
  localparam logic [7:0]  KISS_TYPE_RESET    = 8'h00;

  localparam logic [15:0] MIN_FRAME_LENGTH = 16'd5;
  localparam logic [15:0] MARKER_OCTETS    = 16'd4;

  // Longest burst of octets caused by one received bit: the frame header.
  localparam int unsigned BURST_DEPTH = 6;
  localparam int unsigned BURST_CNT_W = $clog2(BURST_DEPTH + 1);

  localparam int unsigned PADDR_W = 4;

  typedef enum logic [1:0] {
    REG_SYNC_WORD    = 2'd0,
    REG_FRAME_LENGTH = 2'd1,
    REG_KISS_TYPE    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } res_t;

endpackage

@@ hdl/smfk_in_if.sv @@
interface smfk_in_if;
  logic valid;
  logic ready;
  logic rx_bit;

  modport source (output valid, output rx_bit, input ready);
  modport sink (input valid, input rx_bit, output ready);
endinterface

@@ hdl/smfk_out_if.sv @@
interface smfk_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;

  modport source (output valid, output out_byte, output frame_end, input ready);
  modport sink (input valid, input out_byte, input frame_end, output ready);
endinterface

@@ hdl/sync_marker_frame_to_kiss.sv @@
// Sync-marker frame detector with KISS framing. One received bit is taken per
// clock cycle unless the input is stalled. While searching, each bit enters a
// 32-bit shift register that is compared with the sync word and its complement;
// a hit loads the six-octet frame header (FEND, type byte, sync word MSB first)
// into a six-entry burst register, and the input then stalls while that burst
// drains through the single output register, one octet per cycle while the host
// takes them. In the payload an octet completes every eighth bit and yields one
// to three octets (an escaped pair and the closing FEND at most). With the host
// taking octets freely a plain octet costs no stall, while each second or third
// octet holds the input off until it has drained. An octet passes from the burst
// register into the output register, from which the host takes it.
// Configuration is written through the APB port at byte addresses 0 (sync
// word), 4 (frame length) and 8 (type byte).
module sync_marker_frame_to_kiss (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [smfk_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  smfk_in_if.sink                       in_ch,
  smfk_out_if.source                    out_ch
);
  import smfk_pkg::*;

  logic [31:0] sync_word;
  logic [15:0] frame_length;
  logic [7:0]  kiss_type_byte;

  logic [31:0] search_shift;
  logic        in_frame;
  logic        polarity_inverted;
  logic [7:0]  octet_assembly;
  logic [2:0]  bit_index;
  logic [15:0] octets_remaining;

  res_t                   burst [BURST_DEPTH];
  res_t                   burst_next [BURST_DEPTH];
  logic [BURST_CNT_W-1:0] burst_cnt;
  logic [BURST_CNT_W-1:0] burst_cnt_next;

  logic       out_valid;
  res_t       out_res;

  logic       cfg_write;
  cfg_reg_t   cfg_sel;
  logic       accept;
  logic       out_load;

  logic [31:0] shift_next;
  logic        hit_true;
  logic        hit_inv;
  logic [7:0]  octet_full;
  logic [7:0]  octet_byte;
  logic        octet_done;
  logic [15:0] len_clamped;
  logic [15:0] remaining_dec;
  logic        frame_last;
  res_t        esc0;
  res_t        esc1;
  logic        esc_two;
  res_t        close_fend;
  res_t        new_items [BURST_DEPTH];
  logic [BURST_CNT_W-1:0] new_cnt;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_sel   = cfg_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word      <= SYNC_WORD_RESET;
      frame_length   <= FRAME_LENGTH_RESET;
      kiss_type_byte <= KISS_TYPE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        REG_SYNC_WORD:    sync_word      <= pwdata;
        REG_FRAME_LENGTH: frame_length   <= pwdata[15:0];
        REG_KISS_TYPE:    kiss_type_byte <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_SYNC_WORD:    prdata = sync_word;
      REG_FRAME_LENGTH: prdata = {16'd0, frame_length};
      REG_KISS_TYPE:    prdata = {24'd0, kiss_type_byte};
      default:          prdata = 32'd0;
    endcase
  end

  // Handshakes: a new bit is taken once the previous burst is empty or is
  // handing its final octet to the output register in this cycle.
  assign out_load    = (burst_cnt != '0) && (!out_valid || out_ch.ready);
  assign in_ch.ready = (burst_cnt == '0) ||
                       ((burst_cnt == BURST_CNT_W'(1)) && out_load);
  assign accept      = in_ch.valid && in_ch.ready;

  // Per-bit processing
  assign shift_next = {search_shift[30:0], in_ch.rx_bit};
  assign hit_true   = (shift_next == sync_word);
  assign hit_inv    = (shift_next == ~sync_word);

  assign octet_full = {octet_assembly[6:0], in_ch.rx_bit};
  assign octet_byte = octet_full ^ {8{polarity_inverted}};
  assign octet_done = (bit_index == 3'd7);

  assign len_clamped   = (frame_length < MIN_FRAME_LENGTH) ? MIN_FRAME_LENGTH : frame_length;
  assign remaining_dec = octets_remaining - 16'd1;
  assign frame_last    = (remaining_dec == 16'd0);

  always_comb begin
    esc_two = 1'b1;
    esc0    = '{out_byte: KISS_FESC, frame_end: 1'b0};
    if (octet_byte == KISS_FEND) begin
      esc1 = '{out_byte: KISS_TFEND, frame_end: 1'b0};
    end else if (octet_byte == KISS_FESC) begin
      esc1 = '{out_byte: KISS_TFESC, frame_end: 1'b0};
    end else begin
      esc_two = 1'b0;
      esc0    = '{out_byte: octet_byte, frame_end: 1'b0};
      esc1    = '{out_byte: KISS_FEND, frame_end: 1'b1};
    end
  end

  assign close_fend = '{out_byte: KISS_FEND, frame_end: 1'b1};

  always_comb begin
    for (int i = 0; i < BURST_DEPTH; i++) begin
      new_items[i] = close_fend;
    end
    new_cnt = '0;
    if (!in_frame) begin
      new_items[0] = '{out_byte: KISS_FEND,        frame_end: 1'b0};
      new_items[1] = '{out_byte: kiss_type_byte,   frame_end: 1'b0};
      new_items[2] = '{out_byte: sync_word[31:24], frame_end: 1'b0};
      new_items[3] = '{out_byte: sync_word[23:16], frame_end: 1'b0};
      new_items[4] = '{out_byte: sync_word[15:8],  frame_end: 1'b0};
      new_items[5] = '{out_byte: sync_word[7:0],   frame_end: 1'b0};
      if (hit_true || hit_inv) begin
        new_cnt = BURST_CNT_W'(BURST_DEPTH);
      end
    end else if (octet_done) begin
      new_items[0] = esc0;
      new_items[1] = esc1;
      new_cnt = BURST_CNT_W'(1) + BURST_CNT_W'(esc_two) + BURST_CNT_W'(frame_last);
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      search_shift      <= '0;
      in_frame          <= 1'b0;
      polarity_inverted <= 1'b0;
      octet_assembly    <= '0;
      bit_index         <= '0;
      octets_remaining  <= '0;
    end else if (accept) begin
      if (!in_frame) begin
        search_shift <= shift_next;
        if (hit_true || hit_inv) begin
          in_frame          <= 1'b1;
          polarity_inverted <= !hit_true;
          octets_remaining  <= len_clamped - MARKER_OCTETS;
          octet_assembly    <= '0;
          bit_index         <= '0;
        end
      end else begin
        octet_assembly <= octet_full;
        bit_index      <= bit_index + 3'd1;
        if (octet_done) begin
          octets_remaining <= remaining_dec;
          if (frame_last) begin
            in_frame <= 1'b0;
          end
        end
      end
    end
  end

  // Burst register: loaded whole on a transaction, shifted one entry per
  // octet handed to the output register.
  always_comb begin
    burst_cnt_next = burst_cnt;
    for (int i = 0; i < BURST_DEPTH; i++) begin
      burst_next[i] = burst[i];
    end
    if (accept) begin
      burst_cnt_next = new_cnt;
      for (int i = 0; i < BURST_DEPTH; i++) begin
        burst_next[i] = new_items[i];
      end
    end else if (out_load) begin
      burst_cnt_next = burst_cnt - BURST_CNT_W'(1);
      for (int i = 0; i < BURST_DEPTH - 1; i++) begin
        burst_next[i] = burst[i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_cnt <= '0;
    end else begin
      burst_cnt <= burst_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < BURST_DEPTH; i++) begin
      burst[i] <= burst_next[i];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res <= burst[0];
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.out_byte  = out_res.out_byte;
  assign out_ch.frame_end = out_res.frame_end;

`ifndef SYNTHESIS
  a_burst_bound: assert property (@(posedge clk) disable iff (rst)
    burst_cnt <= BURST_CNT_W'(BURST_DEPTH))
    else $error("burst count beyond its depth");

  a_header_loaded: assert property (@(posedge clk) disable iff (rst)
    $rose(in_frame) |-> burst_cnt == BURST_CNT_W'(BURST_DEPTH))
    else $error("frame opened without a full header burst");

  a_close_is_fend: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.frame_end |-> out_res.out_byte == KISS_FEND)
    else $error("frame end marked on an octet other than FEND");

  a_frame_closes_on_octet: assert property (@(posedge clk) disable iff (rst)
    $fell(in_frame) |-> $past(accept) && $past(bit_index) == 3'd7)
    else $error("frame closed away from an octet boundary");
`endif

endmodule

@@ verif/sync_marker_frame_to_kiss_tb.sv @@
module sync_marker_frame_to_kiss_tb;
  import smfk_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned RANDOM_BITS  = 80;
  localparam int unsigned LONG_HOLD    = 400;

  // Mirrors the block: register copies, the marker search and octet assembly,
  // and the queue of KISS octets still to arrive at the host side.
  class kiss_octet_scoreboard;
    logic [31:0] sync_word;
    logic [15:0] frame_length;
    logic [7:0]  kiss_type;
    logic [31:0] search_shift;
    bit          in_frame;
    bit          polarity_inv;
    logic [7:0]  octet_acc;
    logic [2:0]  bit_idx;
    logic [15:0] octets_left;
    res_t        pending_octets[$];
    int unsigned mismatches;
    int unsigned octets_seen;

    function new();
      sync_word    = SYNC_WORD_RESET;
      frame_length = FRAME_LENGTH_RESET;
      kiss_type    = KISS_TYPE_RESET;
      search_shift = '0;
      in_frame     = 1'b0;
      polarity_inv = 1'b0;
      octet_acc    = '0;
      bit_idx      = '0;
      octets_left  = '0;
      mismatches   = 0;
      octets_seen  = 0;
    endfunction

    function void set_reg(cfg_reg_t r, logic [31:0] v);
      case (r)
        REG_SYNC_WORD:    sync_word = v;
        REG_FRAME_LENGTH: frame_length = v[15:0];
        REG_KISS_TYPE:    kiss_type = v[7:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(cfg_reg_t r);
      case (r)
        REG_SYNC_WORD:    return sync_word;
        REG_FRAME_LENGTH: return {16'h0000, frame_length};
        REG_KISS_TYPE:    return {24'h000000, kiss_type};
        default:          return '0;
      endcase
    endfunction

    function void check_readback(cfg_reg_t r, logic [31:0] data);
      if (data !== reg_value(r)) begin
        mismatches++;
        if (mismatches <= 10)
          $display("register %s read: expected %08h, got %08h",
                   r.name(), reg_value(r), data);
      end
    endfunction

    function void queue_octet(logic [7:0] v, logic last);
      res_t r;
      r.out_byte  = v;
      r.frame_end = last;
      pending_octets.push_back(r);
    endfunction

    function void note_rx_bit(logic b);
      logic [7:0]  octet;
      logic [15:0] len;
      if (!in_frame) begin
        search_shift = {search_shift[30:0], b};
        if (search_shift == sync_word || search_shift == ~sync_word) begin
          polarity_inv = (search_shift != sync_word);
          len = (frame_length < MIN_FRAME_LENGTH) ? MIN_FRAME_LENGTH : frame_length;
          queue_octet(KISS_FEND, 1'b0);
          queue_octet(kiss_type, 1'b0);
          for (int i = 3; i >= 0; i--)
            queue_octet(sync_word[8*i +: 8], 1'b0);
          in_frame    = 1'b1;
          octets_left = len - MARKER_OCTETS;
          octet_acc   = '0;
          bit_idx     = '0;
        end
        return;
      end
      octet_acc[3'd7 - bit_idx] = b;
      bit_idx = bit_idx + 3'd1;
      if (bit_idx != 3'd0)
        return;
      octet = polarity_inv ? ~octet_acc : octet_acc;
      if (octet == KISS_FEND) begin
        queue_octet(KISS_FESC, 1'b0);
        queue_octet(KISS_TFEND, 1'b0);
      end else if (octet == KISS_FESC) begin
        queue_octet(KISS_FESC, 1'b0);
        queue_octet(KISS_TFESC, 1'b0);
      end else begin
        queue_octet(octet, 1'b0);
      end
      octet_acc   = '0;
      octets_left = octets_left - 16'd1;
      if (octets_left == 16'd0) begin
        queue_octet(KISS_FEND, 1'b1);
        in_frame = 1'b0;
      end
    endfunction

    function void check_octet(logic [7:0] v, logic last);
      res_t want;
      octets_seen++;
      if (pending_octets.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("octet %0d: none expected, got %02h end=%0b", octets_seen, v, last);
        return;
      end
      want = pending_octets.pop_front();
      if (want.out_byte !== v || want.frame_end !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("octet %0d: expected %02h end=%0b, got %02h end=%0b",
                   octets_seen, want.out_byte, want.frame_end, v, last);
      end
    endfunction

    function int unsigned pending();
      return pending_octets.size();
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  smfk_in_if  in_ch();
  smfk_out_if out_ch();

  kiss_octet_scoreboard sb = new();

  bit          idle_on;
  bit          hold_req;
  int unsigned bits_sent;

  sync_marker_frame_to_kiss DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Host side: takes octets, stalls in short random bursts, and once holds off
  // long enough for the burst register to fill and the bit input to stall.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready)
        sb.check_octet(out_ch.out_byte, out_ch.frame_end);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req && out_ch.valid) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD - 1;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(1, 9) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
        quiet = 0;
      else
        quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_bit(input logic b);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.rx_bit <= b;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_rx_bit(b);
    bits_sent++;
  endtask

  task automatic send_octet(input logic [7:0] v);
    for (int i = 7; i >= 0; i--)
      send_bit(v[i]);
  endtask

  // A broken marker has one bit flipped, so it should normally not be found.
  task automatic send_marker(input bit inverted, input bit broken);
    logic [31:0] marker;
    int unsigned flip;
    marker = inverted ? ~sb.sync_word : sb.sync_word;
    if (broken) begin
      flip = $urandom_range(0, 31);
      marker[flip] = ~marker[flip];
    end
    for (int i = 31; i >= 0; i--)
      send_bit(marker[i]);
  endtask

  // Payload is biased towards octets that need escaping once the polarity
  // correction has been applied.
  function automatic logic [7:0] payload_octet(input bit inverted);
    logic [7:0] v;
    case ($urandom_range(0, 5))
      0:       v = KISS_FEND;
      1:       v = KISS_FESC;
      default: v = 8'($urandom);
    endcase
    return inverted ? ~v : v;
  endfunction

  task automatic send_frame(input bit inverted, input bit broken, input int unsigned noise);
    repeat (noise) send_bit(1'($urandom_range(0, 1)));
    send_marker(inverted, broken);
    while (sb.in_frame)
      send_octet(payload_octet(inverted));
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(r, v);
    @(posedge clk);
  endtask

  task automatic read_reg(input cfg_reg_t r);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {r, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.check_readback(r, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [31:0] word, input logic [15:0] len,
                           input logic [7:0] kiss_type);
    settle();
    write_reg(REG_SYNC_WORD, word);
    write_reg(REG_FRAME_LENGTH, {16'h0000, len});
    write_reg(REG_KISS_TYPE, {24'h000000, kiss_type});
    read_reg(REG_SYNC_WORD);
    read_reg(REG_FRAME_LENGTH);
    read_reg(REG_KISS_TYPE);
  endtask

  function automatic logic [31:0] pick_sync_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [7:0]  plain_octets[5];
    logic [7:0]  inverted_octets[4];
    int unsigned random_start;
    plain_octets    = '{KISS_FEND, KISS_FESC, 8'h00, 8'hFF, KISS_TFEND};
    inverted_octets = '{~KISS_FEND, ~KISS_FESC, 8'hFF, 8'h00};
    rst          <= 1'b1;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.rx_bit <= 1'b0;
    idle_on   = 1'b1;
    hold_req  = 1'b0;
    bits_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values read back, then a frame on the default marker and type
    // byte with only the length shortened.
    read_reg(REG_SYNC_WORD);
    read_reg(REG_FRAME_LENGTH);
    read_reg(REG_KISS_TYPE);
    write_reg(REG_FRAME_LENGTH, 32'd9);
    repeat (10) send_bit(1'($urandom_range(0, 1)));
    send_marker(1'b0, 1'b0);
    foreach (plain_octets[i])
      send_octet(plain_octets[i]);

    // Inverted polarity with payload that needs escaping after correction.
    configure(SYNC_WORD_RESET, 16'd8, 8'h00);
    send_marker(1'b1, 1'b0);
    foreach (inverted_octets[i])
      send_octet(inverted_octets[i]);

    // A length below the minimum still carries one payload octet.
    configure(32'hFFFF_FFFF, 16'd2, 8'hFF);
    send_frame(1'b0, 1'b0, 3);
    send_frame(1'b1, 1'b0, 5);

    hold_req = 1'b1;
    random_start = bits_sent;
    while (bits_sent - random_start < RANDOM_BITS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      configure(pick_sync_word(), 16'($urandom_range(5, 10)), 8'($urandom));
      repeat (2)
        send_frame(1'($urandom_range(0, 1)), ($urandom_range(0, 4) == 0),
                   $urandom_range(0, 16));
    end

    // Closing stretch without idling.
    idle_on = 1'b0;
    configure($urandom, 16'd8, 8'hFF);
    send_frame(1'($urandom_range(0, 1)), 1'b0, 0);
    settle();

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

@@ sync_marker_frame_to_kiss.f @@
hdl/smfk_pkg.sv
hdl/smfk_in_if.sv
hdl/smfk_out_if.sv
hdl/sync_marker_frame_to_kiss.sv
verif/sync_marker_frame_to_kiss_tb.sv
